[src/statistical_outlier_threshold_top_macros.svh]
// assertion macros for the statistical outlier threshold block
`ifndef STATISTICAL_OUTLIER_THRESHOLD_TOP_MACROS_SVH
`define STATISTICAL_OUTLIER_THRESHOLD_TOP_MACROS_SVH

// same-cycle implication
`define SOT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sot_pkg.sv]
// types, constants and codes shared by the statistical outlier threshold block
package sot_pkg;

   localparam int DIST_W         = 24;
   localparam int IDX_W          = 16;
   localparam int MULT_W         = 16;
   localparam int THR_W          = 42;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_IDX_W      = CSR_ADDR_W - 2;
   localparam int VAR_W          = 64;
   localparam int SQ_CAP_W       = 64;
   localparam int ROOT_STEPS     = 32;
   localparam int TERM_SHIFT     = 8;
   localparam int MAX_POINTS_DEF = 65536;
   localparam int VALUE_BITS_DEF = 24;

   localparam logic [MULT_W-1:0]    MULT_RESET   = 16'd256;
   localparam logic                 KIND_LOAD    = 1'b0;
   localparam logic                 KIND_TEST    = 1'b1;
   localparam logic                 STATUS_OK    = 1'b0;
   localparam logic                 STATUS_FEW   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MULT = 1'b0;

   typedef struct packed {
      logic              kind;
      logic [DIST_W-1:0] mean_distance;
      logic [IDX_W-1:0]  point_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic             keep;
      logic             status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_TEST,
      ST_MDIV,
      ST_AMUL,
      ST_BMUL,
      ST_DIFF,
      ST_VDIV,
      ST_ROOT,
      ST_KMUL,
      ST_RND,
      ST_THR,
      ST_RESP
   } state_type;

endpackage

[src/statistical_outlier_threshold_top.sv]
// load item: ST_LOAD, then back to idle; test with frozen threshold or few samples: ST_TEST, then ST_RESP
// first test item of a set: mean divide, two multiplies, difference, variance divide, root, k multiply, rounding
// the threshold is formed bit-serially on one shared add/subtract unit under the sequencer
// next item taken the cycle after a result enters the output register
// synchronous reset clears counts, sums, threshold, sequencer and output valid
// multiplier register resets to 1.0 (256 in Q8.8)
`include "statistical_outlier_threshold_top_macros.svh"

module statistical_outlier_threshold_top #(
   parameter int MAX_POINTS = sot_pkg::MAX_POINTS_DEF,
   parameter int VALUE_BITS = sot_pkg::VALUE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sot_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sot_pkg::rsp_type                  rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sot_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sot_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sot_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int VB     = (VALUE_BITS < sot_pkg::DIST_W) ? VALUE_BITS : sot_pkg::DIST_W;
   localparam int LOG_N  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = VB + LOG_N;
   localparam int SQ_RAW = 2 * VB + LOG_N;
   localparam int SQ_W   = (SQ_RAW < sot_pkg::SQ_CAP_W) ? SQ_RAW : sot_pkg::SQ_CAP_W;
   localparam int A_W    = CNT_W + SQ_W;
   localparam int B_W    = 2 * SUM_W;
   localparam int AB_W   = (A_W > B_W) ? A_W : B_W;
   localparam int W      = (AB_W > sot_pkg::VAR_W) ? AB_W : sot_pkg::VAR_W + 1;
   localparam int DV_W   = 2 * CNT_W;
   localparam int KM_W   = sot_pkg::MULT_W + 1;
   localparam int STEP_W = $clog2(W);
   localparam logic [W-1:0] ROOT_BIT = W'(1) << (sot_pkg::VAR_W - 2);
   localparam logic [W:0]   RND_ADD  = (W + 1)'((1 << sot_pkg::TERM_SHIFT) - 1);

   // control and statistics
   sot_pkg::state_type                state_ff, state_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [SUM_W-1:0]                  sum_ff, sum_in;
   logic [SQ_W-1:0]                   sq_ff, sq_in;
   logic signed [sot_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic                              ready_ff, ready_in;
   logic [sot_pkg::MULT_W-1:0]        mult_ff, mult_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sot_pkg::rsp_type                  rsp_ff, rsp_in;

   // item and work registers
   logic [VB-1:0]                     val_ff, val_in;
   logic [2*VB-1:0]                   sqv_ff, sqv_in;
   logic [sot_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic                              few_ff, few_in;
   logic [W-1:0]                      a_ff, a_in;
   logic [W-1:0]                      q_ff, q_in;
   logic [W-1:0]                      d_ff, d_in;
   logic [W-1:0]                      b_ff, b_in;
   logic [VB-1:0]                     mean_ff, mean_in;
   logic                              neg_ff, neg_in;
   logic [STEP_W-1:0]                 step_ff, step_in;

   // shared unit
   logic [W:0]                        alu_a, alu_b, alu_res;
   logic                              alu_sub;
   logic                              alu_borrow;
   logic [W-1:0]                      div_shift, div_rem, div_q;
   logic [W-1:0]                      mul_acc, mul_q;
   logic [W-1:0]                      root_x, root_res;

   logic [VB-1:0]                     req_val;
   logic [CNT_W-1:0]                  cnt_base;
   logic [SUM_W-1:0]                  sum_base;
   logic [SQ_W-1:0]                   sq_base;
   logic [DV_W-1:0]                   dv;
   logic [KM_W-1:0]                   mult_ext, mult_abs;
   logic                              csr_write;

   assign req_val   = req_item.mean_distance[VB-1:0];
   assign cnt_base  = ready_ff ? '0 : cnt_ff;
   assign sum_base  = ready_ff ? '0 : sum_ff;
   assign sq_base   = ready_ff ? '0 : sq_ff;
   assign dv        = DV_W'(cnt_ff) * DV_W'(cnt_ff - CNT_W'(1));
   assign mult_ext  = {mult_ff[sot_pkg::MULT_W-1], mult_ff};
   assign mult_abs  = mult_ff[sot_pkg::MULT_W-1] ? (~mult_ext + KM_W'(1)) : mult_ext;

   assign div_shift = {a_ff[W-2:0], q_ff[W-1]};
   assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_borrow = alu_res[W];
   assign div_rem   = alu_borrow ? div_shift : alu_res[W-1:0];
   assign div_q     = {q_ff[W-2:0], ~alu_borrow};
   assign mul_acc   = alu_res[W-1:0];
   assign mul_q     = {q_ff[W-2:0], 1'b0};
   assign root_x    = alu_borrow ? a_ff : alu_res[W-1:0];
   assign root_res  = alu_borrow ? (q_ff >> 1) : ((q_ff >> 1) | d_ff);

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign req_ready = (state_ff == sot_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      mult_in = mult_ff;
      if (csr_write && (paddr[sot_pkg::CSR_ADDR_W-1:2] == sot_pkg::CSR_IDX_MULT)) begin
         mult_in = pwdata[sot_pkg::MULT_W-1:0];
      end
   end

   always_comb begin
      unique case (paddr[sot_pkg::CSR_ADDR_W-1:2])
         sot_pkg::CSR_IDX_MULT: prdata = sot_pkg::CSR_DATA_W'(mult_ff);
         default:               prdata = '0;
      endcase
   end

   // operand select for the shared add/subtract unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff) inside
         sot_pkg::ST_MDIV, sot_pkg::ST_VDIV: begin
            alu_a   = {1'b0, div_shift};
            alu_b   = {1'b0, d_ff};
            alu_sub = 1'b1;
         end
         sot_pkg::ST_AMUL, sot_pkg::ST_BMUL, sot_pkg::ST_KMUL: begin
            alu_a = {1'b0, a_ff[W-2:0], 1'b0};
            alu_b = q_ff[W-1] ? {1'b0, d_ff} : '0;
         end
         sot_pkg::ST_DIFF: begin
            alu_a   = {1'b0, b_ff};
            alu_b   = {1'b0, a_ff};
            alu_sub = 1'b1;
         end
         sot_pkg::ST_ROOT: begin
            alu_a   = {1'b0, a_ff};
            alu_b   = {1'b0, q_ff | d_ff};
            alu_sub = 1'b1;
         end
         sot_pkg::ST_RND: begin
            alu_a = {1'b0, a_ff};
            alu_b = neg_ff ? RND_ADD : '0;
         end
         sot_pkg::ST_THR: begin
            alu_a   = (W + 1)'(mean_ff);
            alu_b   = (W + 1)'(a_ff >> sot_pkg::TERM_SHIFT);
            alu_sub = neg_ff;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      thr_in       = thr_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      val_in       = val_ff;
      sqv_in       = sqv_ff;
      idx_in       = idx_ff;
      few_in       = few_ff;
      a_in         = a_ff;
      q_in         = q_ff;
      d_in         = d_ff;
      b_in         = b_ff;
      mean_in      = mean_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      unique case (state_ff)
         sot_pkg::ST_IDLE: begin
            if (req_valid) begin
               val_in   = req_val;
               idx_in   = req_item.point_index;
               sqv_in   = (2 * VB)'(req_val) * (2 * VB)'(req_val);
               state_in = (req_item.kind == sot_pkg::KIND_TEST) ? sot_pkg::ST_TEST
                                                                : sot_pkg::ST_LOAD;
            end
         end
         sot_pkg::ST_LOAD: begin
            if (cnt_base < CNT_W'(MAX_POINTS)) begin
               cnt_in = cnt_base + CNT_W'(1);
               sum_in = sum_base + SUM_W'(val_ff);
               sq_in  = sq_base + SQ_W'(sqv_ff);
            end else begin
               cnt_in = cnt_base;
               sum_in = sum_base;
               sq_in  = sq_base;
            end
            if (ready_ff) begin
               thr_in = '0;
            end
            ready_in = 1'b0;
            state_in = sot_pkg::ST_IDLE;
         end
         sot_pkg::ST_TEST: begin
            if (cnt_ff < CNT_W'(2)) begin
               few_in   = 1'b1;
               ready_in = 1'b1;
               state_in = sot_pkg::ST_RESP;
            end else if (ready_ff) begin
               few_in   = 1'b0;
               state_in = sot_pkg::ST_RESP;
            end else begin
               few_in   = 1'b0;
               a_in     = '0;
               q_in     = W'(sum_ff) << (W - SUM_W);
               d_in     = W'(cnt_ff);
               step_in  = '0;
               state_in = sot_pkg::ST_MDIV;
            end
         end
         sot_pkg::ST_MDIV: begin
            a_in    = div_rem;
            q_in    = div_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               mean_in  = div_q[VB-1:0];
               a_in     = '0;
               q_in     = W'(cnt_ff) << (W - CNT_W);
               d_in     = W'(sq_ff);
               step_in  = '0;
               state_in = sot_pkg::ST_AMUL;
            end
         end
         sot_pkg::ST_AMUL: begin
            a_in    = mul_acc;
            q_in    = mul_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               b_in     = mul_acc;
               a_in     = '0;
               q_in     = W'(sum_ff) << (W - SUM_W);
               d_in     = W'(sum_ff);
               step_in  = '0;
               state_in = sot_pkg::ST_BMUL;
            end
         end
         sot_pkg::ST_BMUL: begin
            a_in    = mul_acc;
            q_in    = mul_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               step_in  = '0;
               state_in = sot_pkg::ST_DIFF;
            end
         end
         sot_pkg::ST_DIFF: begin
            a_in    = '0;
            step_in = '0;
            if (alu_borrow) begin
               q_in     = '0;
               d_in     = ROOT_BIT;
               state_in = sot_pkg::ST_ROOT;
            end else begin
               q_in     = alu_res[W-1:0];
               d_in     = W'(dv);
               state_in = sot_pkg::ST_VDIV;
            end
         end
         sot_pkg::ST_VDIV: begin
            a_in    = div_rem;
            q_in    = div_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(W - 1)) begin
               // quotient saturates to 64 bits
               a_in     = (|div_q[W-1:sot_pkg::VAR_W]) ? W'({sot_pkg::VAR_W{1'b1}})
                                                       : W'(div_q[sot_pkg::VAR_W-1:0]);
               q_in     = '0;
               d_in     = ROOT_BIT;
               step_in  = '0;
               state_in = sot_pkg::ST_ROOT;
            end
         end
         sot_pkg::ST_ROOT: begin
            a_in    = root_x;
            q_in    = root_res;
            d_in    = d_ff >> 2;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(sot_pkg::ROOT_STEPS - 1)) begin
               neg_in   = mult_ff[sot_pkg::MULT_W-1];
               a_in     = '0;
               q_in     = W'(mult_abs) << (W - KM_W);
               d_in     = W'(root_res[sot_pkg::ROOT_STEPS-1:0]);
               step_in  = '0;
               state_in = sot_pkg::ST_KMUL;
            end
         end
         sot_pkg::ST_KMUL: begin
            a_in    = mul_acc;
            q_in    = mul_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(KM_W - 1)) begin
               step_in  = '0;
               state_in = sot_pkg::ST_RND;
            end
         end
         sot_pkg::ST_RND: begin
            a_in     = alu_res[W-1:0];
            state_in = sot_pkg::ST_THR;
         end
         sot_pkg::ST_THR: begin
            thr_in   = alu_res[sot_pkg::THR_W-1:0];
            ready_in = 1'b1;
            state_in = sot_pkg::ST_RESP;
         end
         sot_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_index = idx_ff;
               rsp_in.keep         = !few_ff &&
                  ($signed({{(sot_pkg::THR_W - VB){1'b0}}, val_ff}) <= thr_ff);
               rsp_in.status       = few_ff ? sot_pkg::STATUS_FEW : sot_pkg::STATUS_OK;
               state_in            = sot_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sot_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sot_pkg::ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         thr_ff       <= '0;
         ready_ff     <= 1'b0;
         mult_ff      <= sot_pkg::MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         thr_ff       <= thr_in;
         ready_ff     <= ready_in;
         mult_ff      <= mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      val_ff  <= val_in;
      sqv_ff  <= sqv_in;
      idx_ff  <= idx_in;
      few_ff  <= few_in;
      a_ff    <= a_in;
      q_ff    <= q_in;
      d_ff    <= d_in;
      b_ff    <= b_in;
      mean_ff <= mean_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   `SOT_ASSERT_NEXT(a_load_no_result, clock, reset, state_ff == sot_pkg::ST_LOAD, !$rose(rsp_valid_ff), "load item raised a result")
   `SOT_ASSERT_SAME(a_resp_frozen, clock, reset, state_ff == sot_pkg::ST_RESP, ready_ff, "result without frozen threshold")
   `SOT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_POINTS), "sample count above limit")
   `SOT_ASSERT_SAME(a_divisor_nonzero, clock, reset, state_ff == sot_pkg::ST_MDIV || state_ff == sot_pkg::ST_VDIV, d_ff != '0, "division by zero")

endmodule

[bench/statistical_outlier_threshold_top_tb.sv]
// testbench for the statistical outlier threshold block: mean plus k sigma keep predictor
`timescale 1ns / 1ps

module statistical_outlier_threshold_top_tb;
   import sot_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int WATCH_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 10;
   localparam int TAIL_CYCLES   = 250;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int PHASE_ITEMS   = 220;
   localparam int WIDE_LOADS    = 40;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_item;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   statistical_outlier_threshold_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #CLK_HALF clock = ~clock;

   class outlier_scoreboard;
      logic [16:0]        count;
      logic [39:0]        dist_sum;
      logic [63:0]        sq_sum;
      longint             threshold;
      bit                 frozen;
      logic signed [15:0] multiplier;
      rsp_type            verdicts_q[$];
      int                 errors;
      int                 loads, ignored_loads, tests, kept, too_few, formed;

      function new();
         clear_set();
         multiplier = MULT_RESET;
         errors     = 0;
      endfunction

      function void clear_set();
         count     = '0;
         dist_sum  = '0;
         sq_sum    = '0;
         threshold = 0;
         frozen    = 1'b0;
      endfunction

      function logic [63:0] isqrt_floor(logic [63:0] x);
         logic [63:0] r, c;
         int          i;
         r = '0;
         for (i = 31; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c <= x) r = c;
         end
         return r;
      endfunction

      function void freeze_threshold();
         logic [127:0] a, b, q;
         logic [63:0]  variance, sd;
         longint       mean, prod;
         mean = longint'(dist_sum / count);
         a    = 128'(count) * 128'(sq_sum);
         b    = 128'(dist_sum) * 128'(dist_sum);
         if (a < b) begin
            variance = '0;
         end else begin
            q = (a - b) / (128'(count) * 128'(count - 17'd1));
            variance = (q > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : q[63:0];
         end
         sd        = isqrt_floor(variance);
         prod      = longint'(multiplier) * longint'(sd);
         threshold = mean + (prod >>> 8);
         formed++;
      endfunction

      function void note_item(req_type it);
         rsp_type v;
         if (it.kind == KIND_LOAD) begin
            loads++;
            if (frozen) clear_set();
            if (count < MAX_POINTS_DEF) begin
               count++;
               dist_sum += 40'(it.mean_distance);
               sq_sum   += 64'(it.mean_distance) * 64'(it.mean_distance);
            end else begin
               ignored_loads++;
            end
         end else begin
            tests++;
            v.result_index = it.point_index;
            if (count < 2) begin
               frozen   = 1'b1;
               v.keep   = 1'b0;
               v.status = STATUS_FEW;
               too_few++;
            end else begin
               if (!frozen) begin
                  freeze_threshold();
                  frozen = 1'b1;
               end
               v.keep   = (longint'({40'd0, it.mean_distance}) <= threshold);
               v.status = STATUS_OK;
               if (v.keep) kept++;
            end
            verdicts_q.push_back(v);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (verdicts_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending: expected none, actual %0h/%0b/%0b",
                     $time, got.result_index, got.keep, got.status);
            return;
         end
         want = verdicts_q.pop_front();
         if (got.result_index !== want.result_index) begin
            errors++;
            $display("%0t: result_index expected %0h actual %0h",
                     $time, want.result_index, got.result_index);
         end
         if (got.keep !== want.keep) begin
            errors++;
            $display("%0t: keep for index %0h expected %0b actual %0b",
                     $time, want.result_index, want.keep, got.keep);
         end
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status for index %0h expected %0b actual %0b",
                     $time, want.result_index, want.status, got.status);
         end
      endfunction
   endclass

   outlier_scoreboard sb;

   int burst_left   = 0;
   bit gaps_on      = 1'b1;
   int offered      = 0;
   bit hold_req     = 1'b0;
   int hold_left    = 0;
   int rx_cycle     = 0;
   int rx_mode      = 0;
   int idle_cycles  = 0;
   int phases       = 0;

   // monitors
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_item(req_item);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   // receiver: windowed stall modes plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
         rx_cycle++;
         case (rx_mode)
            0, 1: rsp_ready <= 1'b1;
            2: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCH_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCH_LIMIT);
         $display("statistical_outlier_threshold_top: mismatch");
         $finish;
      end
   end

   function automatic req_type make_item(logic kind, logic [DIST_W-1:0] dist_val,
                                         logic [IDX_W-1:0] idx);
      req_type it;
      it.kind          = kind;
      it.mean_distance = dist_val;
      it.point_index   = idx;
      return it;
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return IDX_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [DIST_W-1:0] near(int center, int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > int'(DIST_MAX)) v = int'(DIST_MAX);
      return DIST_W'(v);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (gaps_on && $urandom_range(0, 3) != 0)
            gap = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      offered++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.verdicts_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_multiplier(input logic [MULT_W-1:0] m);
      logic [15:0] upper;
      upper = 16'($urandom_range(0, 65535));
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_IDX_MULT, 2'b00};
      pwdata  <= {upper, m};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.multiplier = m;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[MULT_W-1:0] !== m) begin
         sb.errors++;
         $display("%0t: multiplier readback expected %0h actual %0h",
                  $time, m, prdata[MULT_W-1:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_value(input int center, input int spread);
      logic [DIST_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = DIST_W'($urandom_range(0, int'(DIST_MAX)));
         1: v = $urandom_range(0, 1) ? DIST_MAX : '0;
         2, 3: begin
            if (sb.frozen && sb.threshold >= 0 && sb.threshold <= longint'(DIST_MAX))
               v = near(int'(sb.threshold), 1);
            else
               v = near(center, 3 * spread);
         end
         default: v = near(center, 3 * spread);
      endcase
      offer(make_item(KIND_TEST, v, rand_index()));
   endtask

   task automatic run_set(input int n_loads, input int n_tests);
      int center, spread, i;
      center = $urandom_range(0, int'(DIST_MAX));
      spread = 1 << $urandom_range(0, 20);
      for (i = 0; i < n_loads; i++)
         offer(make_item(KIND_LOAD, near(center, spread), rand_index()));
      for (i = 0; i < n_tests; i++)
         test_value(center, spread);
   endtask

   task automatic noise();
      int i, n;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
         offer(make_item(logic'($urandom_range(0, 1)),
                         DIST_W'($urandom_range(0, int'(DIST_MAX))), rand_index()));
   endtask

   initial begin
      int                start_count, phase_end, pick, i;
      logic [MULT_W-1:0] m;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty set, then a single sample
      offer(make_item(KIND_TEST, '0, '0));
      offer(make_item(KIND_LOAD, 24'h123456, 16'h0001));
      offer(make_item(KIND_TEST, 24'h123456, '1));
      // extremes at reset multiplier
      offer(make_item(KIND_LOAD, '0, 16'h0002));
      offer(make_item(KIND_LOAD, DIST_MAX, 16'hFFFE));
      offer(make_item(KIND_TEST, '0, 16'h0003));
      offer(make_item(KIND_TEST, DIST_MAX, '1));
      offer(make_item(KIND_TEST, 24'h7FFFFF, '0));
      // zero variance
      offer(make_item(KIND_LOAD, 24'd5, 16'h0010));
      offer(make_item(KIND_LOAD, 24'd5, 16'h0011));
      offer(make_item(KIND_LOAD, 24'd5, 16'h0012));
      offer(make_item(KIND_TEST, 24'd5, 16'h0013));
      offer(make_item(KIND_TEST, 24'd6, 16'h0014));
      // new multiplier must not touch the frozen threshold
      drain();
      write_multiplier(16'h8000);
      offer(make_item(KIND_TEST, 24'd6, 16'h0015));
      offer(make_item(KIND_TEST, 24'd5, 16'h0016));
      // negative threshold
      offer(make_item(KIND_LOAD, 24'd100, 16'h0020));
      offer(make_item(KIND_LOAD, 24'd200, 16'h0021));
      offer(make_item(KIND_LOAD, 24'd300, 16'h0022));
      offer(make_item(KIND_TEST, 24'd0, 16'h0023));
      offer(make_item(KIND_TEST, 24'd100, 16'h0024));

      // set of values at the top of the range with the largest multiplier
      drain();
      write_multiplier(16'h7FFF);
      gaps_on = 1'b0;
      for (i = 0; i < WIDE_LOADS; i++)
         offer(make_item(KIND_LOAD, DIST_MAX - DIST_W'($urandom_range(0, 3)), rand_index()));
      offer(make_item(KIND_TEST, DIST_MAX, 16'h0030));
      offer(make_item(KIND_TEST, '0, 16'h0031));
      for (i = 0; i < 3; i++) test_value(int'(DIST_MAX), 4);
      gaps_on = 1'b1;

      start_count = offered;
      while (offered - start_count < RANDOM_ITEMS) begin
         drain();
         case (phases % 8)
            0: m = '0;
            1: m = 16'h7FFF;
            2: m = 16'h8000;
            3: m = MULT_RESET;
            4: m = 16'hFF00;
            5: m = 16'h0200;
            default: m = MULT_W'($urandom_range(0, 65535));
         endcase
         write_multiplier(m);
         gaps_on = (phases % 3) != 2;
         if (phases == 0) begin
            hold_req = 1'b1;
            run_set(4, 20);
         end
         phase_end = offered + PHASE_ITEMS;
         while (offered < phase_end && offered - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) noise();
            else if (pick < 4) run_set($urandom_range(0, 1), $urandom_range(1, 4));
            else if (pick < 6) run_set(0, $urandom_range(1, 6));
            else if (pick == 6) run_set($urandom_range(25, 300), $urandom_range(1, 10));
            else run_set($urandom_range(2, 24), $urandom_range(1, 12));
         end
         phases++;
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d loads (%0d past a full set) and %0d tests over %0d multipliers",
               sb.loads, sb.ignored_loads, sb.tests, phases + 2);
      $display("%0d thresholds formed, %0d points kept, %0d tests with too few samples",
               sb.formed, sb.kept, sb.too_few);
      if (sb.errors == 0)
         $display("statistical_outlier_threshold_top: match");
      else
         $display("statistical_outlier_threshold_top: mismatch");
      $finish;
   end

endmodule
